[hdl/sfp_pkg.sv]
// Shared types, constants and the CRC-16 step for the status frame parser.
// No dependencies; every other file in hdl/ refers to this package.

package sfp_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned MAX_FRAME_DEF = 256;

  localparam logic [BYTE_W-1:0] BYTE_FF   = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_FD   = 8'hFD;
  localparam logic [BYTE_W-1:0] BYTE_00   = 8'h00;
  localparam logic [BYTE_W-1:0] INST_STATUS = 8'h55;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 16'h8005;
  localparam logic [BYTE_W-1:0] EXPECTED_ID_RST = 8'h01;
  localparam logic [LEN_W-1:0]  MIN_LEN   = 16'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Register index of expected_id on the configuration port
  localparam logic [0:0] REG_EXPECTED_ID = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    FS_OK        = 3'd0,
    FS_TOO_SHORT = 3'd1,
    FS_TOO_LONG  = 3'd2,
    FS_BAD_INST  = 3'd3,
    FS_BAD_ID    = 3'd4,
    FS_BAD_CRC   = 3'd5
  } frame_status_e;

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } in_byte_t;

  typedef struct packed {
    logic                result_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   servo_error;
    logic [STATUS_W-1:0] frame_status;
    logic [COUNT_W-1:0]  payload_count;
    logic                frame_last;
  } result_t;

  // CRC-16, MSB first, no reflection, one byte
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // CRC after FF FF FD 00
  localparam logic [CRC_W-1:0] HDR_CRC =
    crc_byte(crc_byte(crc_byte(crc_byte(16'h0000, BYTE_FF), BYTE_FF), BYTE_FD), BYTE_00);

endpackage

[hdl/sfp_rx_if.sv]
// Receive byte channel: valid/ready handshake with one byte of payload.
// Depends on sfp_pkg for widths.

interface sfp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [sfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[hdl/sfp_res_if.sv]
// Result channel: payload bytes and end-of-frame status, valid/ready handshake.
// Depends on sfp_pkg for widths.

interface sfp_res_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [sfp_pkg::BYTE_W-1:0]   payload_byte;
  logic [sfp_pkg::BYTE_W-1:0]   servo_error;
  logic [sfp_pkg::STATUS_W-1:0] frame_status;
  logic [sfp_pkg::COUNT_W-1:0]  payload_count;
  logic                        frame_last;

  modport source (output valid, output result_kind, output payload_byte,
                  output servo_error, output frame_status, output payload_count,
                  output frame_last, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input servo_error, input frame_status, input payload_count,
                  input frame_last, output ready);
endinterface

[hdl/sfp_apb_regs.sv]
// APB configuration register: expected_id.
// Depends on sfp_pkg.

module sfp_apb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sfp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sfp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sfp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [sfp_pkg::BYTE_W-1:0]      expected_id_o
);

  logic [sfp_pkg::BYTE_W-1:0] expected_id_q, expected_id_d;
  logic                       sel_id;

  assign pready = 1'b1;
  assign sel_id = (paddr[sfp_pkg::APB_ADDR_W-1] == sfp_pkg::REG_EXPECTED_ID);

  always_comb begin
    expected_id_d = expected_id_q;
    if (psel && penable && pwrite && sel_id) begin
      expected_id_d = pwdata[sfp_pkg::BYTE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_id) begin
      prdata = {{(sfp_pkg::APB_DATA_W-sfp_pkg::BYTE_W){1'b0}}, expected_id_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_id_q <= sfp_pkg::EXPECTED_ID_RST;
    end else begin
      expected_id_q <= expected_id_d;
    end
  end

  assign expected_id_o = expected_id_q;

endmodule

[hdl/sfp_in_stage.sv]
// Input register for received bytes; takes a new byte when it is empty or the held one
// moves on. Depends on sfp_pkg and sfp_rx_if.

module sfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfp_rx_if.sink            rx_i,
  input  logic              take_i,
  output sfp_pkg::in_byte_t in_o
);

  logic                       vld_q, vld_d;
  logic [sfp_pkg::BYTE_W-1:0] data_q;
  logic                       rdy;

  assign rdy      = !vld_q || take_i;
  assign rx_i.ready = rdy;

  always_comb begin
    vld_d = vld_q;
    if (rdy) begin
      vld_d = rx_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && rx_i.valid) begin
      data_q <= rx_i.rx_byte;
    end
  end

  assign in_o.vld  = vld_q;
  assign in_o.data = data_q;

endmodule

[hdl/sfp_parser.sv]
// Frame state machine, CRC, unstuffing and the result register.
// Depends on sfp_pkg and sfp_res_if.

module sfp_parser #(
  parameter int unsigned MaxFrame = sfp_pkg::MAX_FRAME_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sfp_pkg::in_byte_t          in_i,
  input  logic [sfp_pkg::BYTE_W-1:0] expected_id_i,
  output logic                       take_o,
  sfp_res_if.source                  res_o
);

  localparam int unsigned PosW = $clog2(MaxFrame);
  localparam int unsigned LenW = sfp_pkg::LEN_W;

  typedef enum logic [7:0] {
    ST_HUNT    = 8'b0000_0001,
    ST_ID      = 8'b0000_0010,
    ST_LEN_L   = 8'b0000_0100,
    ST_LEN_H   = 8'b0000_1000,
    ST_INST    = 8'b0001_0000,
    ST_ERR     = 8'b0010_0000,
    ST_PAYLOAD = 8'b0100_0000,
    ST_CRC     = 8'b1000_0000
  } stage_e;

  stage_e                        stage_q, stage_d;
  logic [1:0]                    hdr_q, hdr_d;
  logic [PosW-1:0]               pos_q, pos_d;
  logic [PosW-1:0]               pos_inc;
  logic [LenW-1:0]               len_q, len_d;
  logic [LenW-1:0]               len_full;
  logic [sfp_pkg::CRC_W-1:0]     crc_q, crc_d;
  logic [sfp_pkg::CRC_W-1:0]     crc_next;
  logic [sfp_pkg::BYTE_W-1:0]    crc_lo_q, crc_lo_d;
  logic [1:0]                    ff_q, ff_d;
  logic                          swallow_q, swallow_d;
  logic                          id_ok_q, id_ok_d;
  logic                          inst_ok_q, inst_ok_d;
  logic [sfp_pkg::BYTE_W-1:0]    err_q, err_d;
  logic [sfp_pkg::COUNT_W-1:0]   cnt_q, cnt_d;

  logic                          out_vld_q, out_vld_d;
  sfp_pkg::result_t              out_q;
  sfp_pkg::result_t              res;
  logic                          res_vld;
  logic                          fire;
  logic                          emit;
  logic [sfp_pkg::BYTE_W-1:0]    b;
  logic [sfp_pkg::CRC_W-1:0]     got_crc;

  assign b        = in_i.data;
  assign fire     = in_i.vld && (!out_vld_q || res_o.ready);
  assign take_o   = fire;
  assign crc_next = sfp_pkg::crc_byte(crc_q, b);
  assign pos_inc  = pos_q + 1'b1;
  assign len_full = {b, len_q[sfp_pkg::BYTE_W-1:0]};
  assign got_crc  = {b, crc_lo_q};

  always_comb begin
    stage_d   = stage_q;
    hdr_d     = hdr_q;
    pos_d     = pos_q;
    len_d     = len_q;
    crc_d     = crc_q;
    crc_lo_d  = crc_lo_q;
    ff_d      = ff_q;
    swallow_d = swallow_q;
    id_ok_d   = id_ok_q;
    inst_ok_d = inst_ok_q;
    err_d     = err_q;
    cnt_d     = cnt_q;
    emit      = 1'b0;
    res_vld   = 1'b0;
    res       = '0;

    if (fire) begin
      case (stage_q)
        ST_HUNT: begin
          case (hdr_q)
            2'd0, 2'd1: begin
              hdr_d = (b == sfp_pkg::BYTE_FF) ? hdr_q + 2'd1 : 2'd0;
            end
            2'd2: begin
              if (b == sfp_pkg::BYTE_FD) begin
                hdr_d = 2'd3;
              end else if (b == sfp_pkg::BYTE_FF) begin
                hdr_d = 2'd2;
              end else begin
                hdr_d = 2'd0;
              end
            end
            default: begin
              if (b == sfp_pkg::BYTE_00) begin
                hdr_d     = 2'd0;
                crc_d     = sfp_pkg::HDR_CRC;
                err_d     = '0;
                cnt_d     = '0;
                id_ok_d   = 1'b0;
                inst_ok_d = 1'b0;
                stage_d   = ST_ID;
              end else begin
                hdr_d = (b == sfp_pkg::BYTE_FF) ? 2'd1 : 2'd0;
              end
            end
          endcase
        end
        ST_ID: begin
          crc_d   = crc_next;
          id_ok_d = (b == expected_id_i);
          stage_d = ST_LEN_L;
        end
        ST_LEN_L: begin
          crc_d   = crc_next;
          len_d   = {{(LenW-sfp_pkg::BYTE_W){1'b0}}, b};
          stage_d = ST_LEN_H;
        end
        ST_LEN_H: begin
          crc_d = crc_next;
          len_d = len_full;
          if (len_full < sfp_pkg::MIN_LEN) begin
            res_vld            = 1'b1;
            res.result_kind    = 1'b1;
            res.frame_status   = sfp_pkg::FS_TOO_SHORT;
            res.frame_last     = 1'b1;
            stage_d            = ST_HUNT;
            hdr_d              = 2'd0;
          end else if (({1'b0, len_full} + 17'd7) > 17'(MaxFrame)) begin
            res_vld            = 1'b1;
            res.result_kind    = 1'b1;
            res.frame_status   = sfp_pkg::FS_TOO_LONG;
            res.frame_last     = 1'b1;
            stage_d            = ST_HUNT;
            hdr_d              = 2'd0;
          end else begin
            stage_d = ST_INST;
          end
        end
        ST_INST: begin
          crc_d     = crc_next;
          inst_ok_d = (b == sfp_pkg::INST_STATUS);
          stage_d   = ST_ERR;
        end
        ST_ERR: begin
          crc_d     = crc_next;
          err_d     = b;
          ff_d      = 2'd0;
          swallow_d = 1'b0;
          pos_d     = '0;
          stage_d   = (len_q == sfp_pkg::MIN_LEN) ? ST_CRC : ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          crc_d = crc_next;
          pos_d = pos_inc;
          if (swallow_q && (b == sfp_pkg::BYTE_FD)) begin
            // drop the stuffed FD
            swallow_d = 1'b0;
            ff_d      = 2'd0;
          end else begin
            swallow_d = 1'b0;
            emit      = 1'b1;
            if (cnt_q != sfp_pkg::COUNT_MAX) begin
              cnt_d = cnt_q + 1'b1;
            end
            if (b == sfp_pkg::BYTE_FF) begin
              if (ff_q != 2'd2) begin
                ff_d = ff_q + 2'd1;
              end
            end else begin
              swallow_d = (ff_q == 2'd2) && (b == sfp_pkg::BYTE_FD);
              ff_d      = 2'd0;
            end
          end
          if (LenW'(pos_inc) >= (len_q - sfp_pkg::MIN_LEN)) begin
            swallow_d = 1'b0;
            ff_d      = 2'd0;
            pos_d     = '0;
            stage_d   = ST_CRC;
          end
          if (emit && id_ok_q && inst_ok_q) begin
            res_vld          = 1'b1;
            res.payload_byte = b;
          end
        end
        ST_CRC: begin
          if (pos_q == '0) begin
            crc_lo_d = b;
            pos_d    = {{(PosW-1){1'b0}}, 1'b1};
          end else begin
            res_vld           = 1'b1;
            res.result_kind   = 1'b1;
            res.servo_error   = err_q;
            res.payload_count = cnt_q;
            res.frame_last    = 1'b1;
            if (!inst_ok_q) begin
              res.frame_status = sfp_pkg::FS_BAD_INST;
            end else if (!id_ok_q) begin
              res.frame_status = sfp_pkg::FS_BAD_ID;
            end else if (got_crc != crc_q) begin
              res.frame_status = sfp_pkg::FS_BAD_CRC;
            end else begin
              res.frame_status = sfp_pkg::FS_OK;
            end
            pos_d   = '0;
            stage_d = ST_HUNT;
            hdr_d   = 2'd0;
          end
        end
        default: begin
          stage_d = ST_HUNT;
          hdr_d   = 2'd0;
        end
      endcase
    end
  end

  // Hold a result until taken; load a new one in the same cycle it drains
  always_comb begin
    out_vld_d = out_vld_q;
    if (res_vld) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q   <= ST_HUNT;
      hdr_q     <= 2'd0;
      pos_q     <= '0;
      len_q     <= '0;
      crc_q     <= '0;
      crc_lo_q  <= '0;
      ff_q      <= 2'd0;
      swallow_q <= 1'b0;
      id_ok_q   <= 1'b0;
      inst_ok_q <= 1'b0;
      err_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      stage_q   <= stage_d;
      hdr_q     <= hdr_d;
      pos_q     <= pos_d;
      len_q     <= len_d;
      crc_q     <= crc_d;
      crc_lo_q  <= crc_lo_d;
      ff_q      <= ff_d;
      swallow_q <= swallow_d;
      id_ok_q   <= id_ok_d;
      inst_ok_q <= inst_ok_d;
      err_q     <= err_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_vld) begin
      out_q <= res;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.result_kind   = out_q.result_kind;
  assign res_o.payload_byte  = out_q.payload_byte;
  assign res_o.servo_error   = out_q.servo_error;
  assign res_o.frame_status  = out_q.frame_status;
  assign res_o.payload_count = out_q.payload_count;
  assign res_o.frame_last    = out_q.frame_last;

endmodule

[hdl/status_frame_parser.sv]
// Status frame parser top level: APB register, input register, parser core.
// Path: bytes pass the input register, then the parser core into the result register.
// Throughput: one byte per cycle while results drain; the input register and the
// result register overlap, so a byte is taken while a finished result still waits.
// Reset: asynchronous, active low; hunts for a header, expected_id is 1.
// Depends on sfp_pkg, sfp_rx_if, sfp_res_if, sfp_apb_regs, sfp_in_stage, sfp_parser.

module status_frame_parser #(
  parameter int unsigned MaxFrame = sfp_pkg::MAX_FRAME_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  sfp_rx_if.sink                         rx_i,
  sfp_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfp_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sfp_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sfp_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic [sfp_pkg::BYTE_W-1:0] expected_id;
  sfp_pkg::in_byte_t          in_byte;
  logic                       take;

  sfp_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .expected_id_o (expected_id)
  );

  sfp_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .take_i (take),
    .in_o   (in_byte)
  );

  sfp_parser #(
    .MaxFrame (MaxFrame)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_byte),
    .expected_id_i (expected_id),
    .take_o        (take),
    .res_o         (res_o)
  );

endmodule

[bench/sfp_frame_checker.sv]
// Checker for the status frame parser: follows the byte channel and APB writes,
// predicts every result transaction and compares it with the result channel.
// Depends on sfp_pkg and the channel interfaces sfp_rx_if and sfp_res_if.

module sfp_frame_checker
  import sfp_pkg::*;
#(
  parameter int unsigned MaxFrame = MAX_FRAME_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sfp_rx_if                     rx_i,
  sfp_res_if                    res_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int unsigned           error_count_o,
  output int unsigned           pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] ID_REG_ADDR = {REG_EXPECTED_ID, 2'b00};
  localparam int unsigned           PRINT_CAP   = 40;

  typedef enum logic [2:0] {
    SEEK_HDR, GET_ID, GET_LEN_LO, GET_LEN_HI, GET_INST, GET_ERR, GET_BODY, GET_CRC
  } stage_e;

  stage_e            stage;
  logic [2:0]        hdr_seen;
  logic [8:0]        pos;
  logic [15:0]       flen;
  logic [15:0]       crc;
  logic [7:0]        crc_lo;
  logic [1:0]        ff_cnt;
  logic              drop_fd;
  logic              id_match;
  logic              inst_match;
  logic [7:0]        err_byte;
  logic [COUNT_W-1:0] body_cnt;
  logic [7:0]        cfg_id;

  result_t           frame_outputs_q[$];
  int unsigned       err_cnt = 0;

  function automatic logic [15:0] crc16_fold(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = c_in ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  task automatic clear_parser();
    stage      = SEEK_HDR;
    hdr_seen   = '0;
    pos        = '0;
    flen       = '0;
    crc        = '0;
    crc_lo     = '0;
    ff_cnt     = '0;
    drop_fd    = 1'b0;
    id_match   = 1'b0;
    inst_match = 1'b0;
    err_byte   = '0;
    body_cnt   = '0;
    cfg_id     = EXPECTED_ID_RST;
    frame_outputs_q.delete();
  endtask

  // Close the frame with a status transaction and go back to header hunting
  task automatic push_status(input logic [7:0] err, input frame_status_e st,
                             input logic [COUNT_W-1:0] cnt);
    result_t r;
    r               = '0;
    r.result_kind   = 1'b1;
    r.servo_error   = err;
    r.frame_status  = st;
    r.payload_count = cnt;
    r.frame_last    = 1'b1;
    frame_outputs_q = {frame_outputs_q, r};
    stage    = SEEK_HDR;
    hdr_seen = '0;
  endtask

  task automatic close_body();
    drop_fd = 1'b0;
    ff_cnt  = '0;
    pos     = '0;
    stage   = GET_CRC;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic          emit;
    result_t       r;
    logic [15:0]   rx_crc;
    frame_status_e st;
    // the CRC field itself is not folded in
    if (stage != SEEK_HDR && stage != GET_CRC) begin
      crc = crc16_fold(crc, b);
    end
    case (stage)
      SEEK_HDR: begin
        if (hdr_seen <= 3'd1) begin
          hdr_seen = (b == BYTE_FF) ? 3'(hdr_seen + 3'd1) : 3'd0;
        end else if (hdr_seen == 3'd2) begin
          hdr_seen = (b == BYTE_FD) ? 3'd3 : ((b == BYTE_FF) ? 3'd2 : 3'd0);
        end else if (b == BYTE_00) begin
          hdr_seen   = '0;
          crc        = crc16_fold(crc16_fold(crc16_fold(crc16_fold(16'h0000, BYTE_FF),
                                                        BYTE_FF), BYTE_FD), BYTE_00);
          err_byte   = '0;
          body_cnt   = '0;
          id_match   = 1'b0;
          inst_match = 1'b0;
          stage      = GET_ID;
        end else begin
          // a failed match may still start a new one
          hdr_seen = (b == BYTE_FF) ? 3'd1 : 3'd0;
        end
      end
      GET_ID: begin
        id_match = (b == cfg_id);
        stage    = GET_LEN_LO;
      end
      GET_LEN_LO: begin
        flen  = {8'h00, b};
        stage = GET_LEN_HI;
      end
      GET_LEN_HI: begin
        flen[15:8] = b;
        if (flen < MIN_LEN) begin
          push_status(8'h00, FS_TOO_SHORT, '0);
        end else if (7 + int'(flen) > int'(MaxFrame)) begin
          push_status(8'h00, FS_TOO_LONG, '0);
        end else begin
          stage = GET_INST;
        end
      end
      GET_INST: begin
        inst_match = (b == INST_STATUS);
        stage      = GET_ERR;
      end
      GET_ERR: begin
        err_byte = b;
        ff_cnt   = '0;
        drop_fd  = 1'b0;
        pos      = '0;
        if (flen == MIN_LEN) begin
          close_body();
        end else begin
          stage = GET_BODY;
        end
      end
      GET_BODY: begin
        emit = 1'b0;
        pos  = pos + 9'd1;
        if (drop_fd && b == BYTE_FD) begin
          // stuffed byte after FF FF FD: drop it
          drop_fd = 1'b0;
          ff_cnt  = '0;
        end else begin
          drop_fd = 1'b0;
          emit    = 1'b1;
          if (body_cnt != COUNT_MAX) begin
            body_cnt = body_cnt + 1'b1;
          end
          if (b == BYTE_FF) begin
            if (ff_cnt < 2'd2) begin
              ff_cnt = ff_cnt + 2'd1;
            end
          end else begin
            if (ff_cnt >= 2'd2 && b == BYTE_FD) begin
              drop_fd = 1'b1;
            end
            ff_cnt = '0;
          end
        end
        if ({7'd0, pos} >= flen - MIN_LEN) begin
          close_body();
        end
        if (emit && id_match && inst_match) begin
          r              = '0;
          r.payload_byte = b;
          frame_outputs_q = {frame_outputs_q, r};
        end
      end
      default: begin
        if (pos == '0) begin
          crc_lo = b;
          pos    = 9'd1;
        end else begin
          rx_crc = {b, crc_lo};
          st     = FS_OK;
          if (!inst_match) begin
            st = FS_BAD_INST;
          end else if (!id_match) begin
            st = FS_BAD_ID;
          end else if (rx_crc != crc) begin
            st = FS_BAD_CRC;
          end
          pos = '0;
          push_status(err_byte, st, body_cnt);
        end
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    if (err_cnt < PRINT_CAP) begin
      $display("[%0t] sfp_frame_checker: %s", $realtime, msg);
    end
    err_cnt++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  task automatic compare_result();
    result_t want;
    if (frame_outputs_q.size() == 0) begin
      report_error($sformatf("result with nothing predicted: kind %0b byte %02h status %0d",
                             res_i.result_kind, res_i.payload_byte, res_i.frame_status));
      return;
    end
    want = frame_outputs_q.pop_front();
    check_field("result_kind",   16'(res_i.result_kind),   16'(want.result_kind));
    check_field("payload_byte",  16'(res_i.payload_byte),  16'(want.payload_byte));
    check_field("servo_error",   16'(res_i.servo_error),   16'(want.servo_error));
    check_field("frame_status",  16'(res_i.frame_status),  16'(want.frame_status));
    check_field("payload_count", 16'(res_i.payload_count), 16'(want.payload_count));
    check_field("frame_last",    16'(res_i.frame_last),    16'(want.frame_last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      pending_count_o <= 0;
      error_count_o   <= err_cnt;
    end else begin
      if (res_i.valid && res_i.ready) begin
        compare_result();
      end
      if (psel && penable && pwrite && pready && paddr == ID_REG_ADDR) begin
        cfg_id = pwdata[7:0];
      end
      if (rx_i.valid && rx_i.ready) begin
        parse_rx_byte(rx_i.rx_byte);
      end
      error_count_o   <= err_cnt;
      pending_count_o <= frame_outputs_q.size();
    end
  end

endmodule

[bench/status_frame_parser_tb.sv]
// Top of the status frame parser bench: clock, reset, APB writes of the id,
// byte stimulus (framed, broken and noise) and the final verdict.
// Depends on sfp_pkg, the channel interfaces, the RTL and sfp_frame_checker.

module status_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfp_pkg::*;

  localparam int unsigned MAX_FRAME_TB = MAX_FRAME_DEF;
  localparam int unsigned MAX_BODY     = MAX_FRAME_TB - 11;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_BYTES  = 200;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned LONG_HOLD_AT = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam logic [APB_ADDR_W-1:0] ID_REG_ADDR = {REG_EXPECTED_ID, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_cnt;
  int unsigned pending_cnt;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt  = 0;
  bit          idle_en    = 1'b1;
  logic [7:0]  cur_id;
  logic [7:0]  frame_buf[$];

  sfp_rx_if  rx_ch();
  sfp_res_if res_ch();

  status_frame_parser #(
    .MaxFrame(MAX_FRAME_TB)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_n),
    .rx_i   (rx_ch),
    .res_o  (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  sfp_frame_checker #(
    .MaxFrame(MAX_FRAME_TB)
  ) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .rx_i           (rx_ch),
    .res_i          (res_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .error_count_o  (fail_cnt),
    .pending_count_o(pending_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status_frame_parser_tb NOT OK");
      $finish;
    end
  end

  // Byte values biased toward the ones the header and the stuffing care about
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(7))
      0, 1:    return BYTE_FF;
      2:       return BYTE_FD;
      3:       return BYTE_00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(3) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame_buf();
    foreach (frame_buf[k]) begin
      send_byte(frame_buf[k]);
    end
  endtask

  // Hold the sender until every predicted transaction is out and the pipe is empty
  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_id_reg(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ID_REG_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Header through error byte, stuffed body of body_len wire bytes, CRC
  task automatic build_frame(input logic [7:0] id, input logic [7:0] inst,
                             input logic [7:0] err, input int unsigned body_len,
                             input bit stuff_on, input bit crc_bad);
    logic [7:0]  body[$];
    logic [7:0]  b;
    logic [15:0] len;
    logic [15:0] c;
    int unsigned run;
    int          k;
    run = 0;
    while (body.size() < body_len) begin
      b = pick_body_byte();
      body = {body, b};
      if (b == BYTE_FF) begin
        run = (run < 2) ? run + 1 : 2;
      end else begin
        if (stuff_on && run >= 2 && b == BYTE_FD && body.size() < body_len) begin
          body = {body, BYTE_FD};
        end
        run = 0;
      end
    end
    len = 16'(body.size() + 4);
    frame_buf = {BYTE_FF, BYTE_FF, BYTE_FD, BYTE_00, id, len[7:0], len[15:8], inst, err};
    foreach (body[i]) begin
      frame_buf = {frame_buf, body[i]};
    end
    c = 16'h0000;
    foreach (frame_buf[i]) begin
      c = c ^ {frame_buf[i], 8'h00};
      for (k = 0; k < 8; k++) begin
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    if (crc_bad) begin
      c = c ^ 16'($urandom_range(1, 16'hFFFF));
    end
    frame_buf = {frame_buf, c[7:0]};
    frame_buf = {frame_buf, c[15:8]};
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned blen;
    int unsigned cut;
    logic [7:0]  id;
    logic [7:0]  inst;
    logic [15:0] len;
    kind = $urandom_range(99);
    // partial headers in front exercise the overlapping match
    case ($urandom_range(9))
      0: send_byte(BYTE_FF);
      1: begin
        send_byte(BYTE_FF);
        send_byte(BYTE_FF);
        send_byte(BYTE_FD);
        send_byte(BYTE_FF);
      end
      default: ;
    endcase
    id   = ($urandom_range(9) != 0) ? cur_id : 8'($urandom);
    inst = ($urandom_range(9) != 0) ? INST_STATUS : 8'($urandom);
    if (kind < 65) begin
      blen = ($urandom_range(19) == 0) ? MAX_BODY : $urandom_range(0, 12);
      build_frame(id, inst, 8'($urandom), blen, $urandom_range(7) != 0, $urandom_range(9) == 0);
      send_frame_buf();
    end else if (kind < 75) begin
      frame_buf = {BYTE_FF, BYTE_FF, BYTE_FD, BYTE_00, id, 8'($urandom_range(0, 3)), 8'h00};
      send_frame_buf();
    end else if (kind < 83) begin
      len = $urandom_range(1) ? 16'(MAX_FRAME_TB - 6) : 16'($urandom_range(MAX_FRAME_TB - 6, 16'hFFFF));
      frame_buf = {BYTE_FF, BYTE_FF, BYTE_FD, BYTE_00, id, len[7:0], len[15:8]};
      send_frame_buf();
    end else if (kind < 90) begin
      // broken frame: whatever follows is parsed as the rest of it
      build_frame(id, inst, 8'($urandom), $urandom_range(0, 8), 1'b1, 1'b0);
      cut = $urandom_range(1, frame_buf.size() - 4);
      repeat (cut) void'(frame_buf.pop_back());
      send_frame_buf();
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(pick_body_byte());
    end
  endtask

  // Result side: random short stalls plus one long hold that backs up the input
  initial begin
    bit held_long;
    held_long = 1'b0;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_long && bytes_sent >= LONG_HOLD_AT) begin
        held_long = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_en && $urandom_range(4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [7:0]  id_plan[5];
    int unsigned phase_end;
    rst_n         <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    cur_id = EXPECTED_ID_RST;

    // overlapping header, then a length below the minimum
    frame_buf = {BYTE_FF, BYTE_FF, BYTE_FF, BYTE_FD, BYTE_00, 8'h01, 8'h03, 8'h00};
    send_frame_buf();
    // largest length value
    frame_buf = {BYTE_FF, BYTE_FF, BYTE_FD, BYTE_00, 8'hFF, 8'hFF, 8'hFF};
    send_frame_buf();
    // shortest good frame, empty body
    build_frame(cur_id, INST_STATUS, 8'hFF, 0, 1'b1, 1'b0);
    send_frame_buf();
    drain();

    id_plan = '{8'h00, 8'hFF, 8'($urandom), EXPECTED_ID_RST, 8'($urandom)};
    foreach (id_plan[p]) begin
      cur_id = id_plan[p];
      write_id_reg(cur_id);
      if (p == $size(id_plan) - 1) begin
        idle_en = 1'b0;
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        send_random_frame();
      end
      drain();
    end

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("status_frame_parser_tb OK");
    end else begin
      $display("status_frame_parser_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sfp_pkg.sv
hdl/sfp_rx_if.sv
hdl/sfp_res_if.sv
hdl/sfp_apb_regs.sv
hdl/sfp_in_stage.sv
hdl/sfp_parser.sv
hdl/status_frame_parser.sv
bench/sfp_frame_checker.sv
bench/status_frame_parser_tb.sv
